// ===== hw/rtl/hsvrgb_pkg.sv =====
// Shared constants for the HSV to RGB colour converter.
// Used by hsvrgb_level and hsv_to_rgb_converter_core; depends on nothing else.
`timescale 1ns / 1ps

package hsvrgb_pkg;

  localparam int HUE_W    = 9;
  localparam int CHAN_W   = 8;
  localparam int SECTOR_W = 4;
  localparam int FRAC_W   = 6;
  localparam int WEIGHT_W = 14;
  localparam int PROD_W   = 22;
  localparam int EST_W    = 33;

  localparam int SECTOR_SPAN  = 60;
  localparam int SECTOR_COUNT = 8;

  localparam logic [WEIGHT_W-1:0] FULL_SCALE  = 14'd15300;
  localparam logic [10:0]         RECIP       = 11'd1096;
  localparam int                  RECIP_SHIFT = 24;

  localparam logic [SECTOR_W-1:0] SECTOR_RED     = 4'd0;
  localparam logic [SECTOR_W-1:0] SECTOR_YELLOW  = 4'd1;
  localparam logic [SECTOR_W-1:0] SECTOR_GREEN   = 4'd2;
  localparam logic [SECTOR_W-1:0] SECTOR_CYAN    = 4'd3;
  localparam logic [SECTOR_W-1:0] SECTOR_BLUE    = 4'd4;

endpackage

// ===== hw/rtl/hsv_to_rgb_converter_core.sv =====
// HSV to RGB colour converter: one request per clock.
// A request's result passes the sector and weight registers, the level units and the output
// register, and is shown on the outputs marked by done.
// Every stage is a register slice and the three level units are pipelined, so
// busy is always low. Reset clears the valid chain only.
// Top level; depends on hsvrgb_pkg and hsvrgb_level.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [hsvrgb_pkg::HUE_W-1:0]        hue,
  input  logic [hsvrgb_pkg::CHAN_W-1:0]       saturation,
  input  logic [hsvrgb_pkg::CHAN_W-1:0]       brightness,
  output logic                                done,
  output logic [hsvrgb_pkg::CHAN_W-1:0]       red,
  output logic [hsvrgb_pkg::CHAN_W-1:0]       green,
  output logic [hsvrgb_pkg::CHAN_W-1:0]       blue
);

  logic [hsvrgb_pkg::SECTOR_W-1:0] sector_c;
  logic [hsvrgb_pkg::HUE_W-1:0]    base_c;

  logic                            valid1;
  logic [hsvrgb_pkg::SECTOR_W-1:0] sector1;
  logic [hsvrgb_pkg::FRAC_W-1:0]   frac1;
  logic [hsvrgb_pkg::CHAN_W-1:0]   sat1;
  logic [hsvrgb_pkg::CHAN_W-1:0]   val1;

  logic                            valid2;
  logic [hsvrgb_pkg::SECTOR_W-1:0] sector2;
  logic [hsvrgb_pkg::CHAN_W-1:0]   val2;
  logic [hsvrgb_pkg::WEIGHT_W-1:0] wp2;
  logic [hsvrgb_pkg::WEIGHT_W-1:0] wq2;
  logic [hsvrgb_pkg::WEIGHT_W-1:0] wt2;

  logic [2:0]                      valid_d;
  logic [hsvrgb_pkg::SECTOR_W-1:0] sector_d [3];
  logic [hsvrgb_pkg::CHAN_W-1:0]   val_d [3];

  logic [hsvrgb_pkg::CHAN_W-1:0]   lvl_p;
  logic [hsvrgb_pkg::CHAN_W-1:0]   lvl_q;
  logic [hsvrgb_pkg::CHAN_W-1:0]   lvl_t;

  logic [hsvrgb_pkg::CHAN_W-1:0]   red_next;
  logic [hsvrgb_pkg::CHAN_W-1:0]   green_next;
  logic [hsvrgb_pkg::CHAN_W-1:0]   blue_next;

  assign busy = 1'b0;

  always_comb begin
    sector_c = '0;
    base_c   = '0;
    for (int k = 1; k <= hsvrgb_pkg::SECTOR_COUNT; k++) begin
      if (hue >= hsvrgb_pkg::HUE_W'(hsvrgb_pkg::SECTOR_SPAN * k)) begin
        sector_c = hsvrgb_pkg::SECTOR_W'(k);
        base_c   = hsvrgb_pkg::HUE_W'(hsvrgb_pkg::SECTOR_SPAN * k);
      end
    end
  end

  hsvrgb_level u_level_p (.clk(clk), .value(val2), .weight(wp2), .level(lvl_p));
  hsvrgb_level u_level_q (.clk(clk), .value(val2), .weight(wq2), .level(lvl_q));
  hsvrgb_level u_level_t (.clk(clk), .value(val2), .weight(wt2), .level(lvl_t));

  always_comb begin
    case (sector_d[2])
      hsvrgb_pkg::SECTOR_RED: begin
        red_next = val_d[2]; green_next = lvl_t; blue_next = lvl_p;
      end
      hsvrgb_pkg::SECTOR_YELLOW: begin
        red_next = lvl_q; green_next = val_d[2]; blue_next = lvl_p;
      end
      hsvrgb_pkg::SECTOR_GREEN: begin
        red_next = lvl_p; green_next = val_d[2]; blue_next = lvl_t;
      end
      hsvrgb_pkg::SECTOR_CYAN: begin
        red_next = lvl_p; green_next = lvl_q; blue_next = val_d[2];
      end
      hsvrgb_pkg::SECTOR_BLUE: begin
        red_next = lvl_t; green_next = lvl_p; blue_next = val_d[2];
      end
      default: begin
        red_next = val_d[2]; green_next = lvl_p; blue_next = lvl_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1  <= 1'b0;
      valid2  <= 1'b0;
      valid_d <= '0;
      done    <= 1'b0;
    end else begin
      valid1  <= start && !busy;
      valid2  <= valid1;
      valid_d <= {valid_d[1:0], valid2};
      done    <= valid_d[2];
    end

    sector1 <= sector_c;
    frac1   <= hsvrgb_pkg::FRAC_W'(hue - base_c);
    sat1    <= saturation;
    val1    <= brightness;

    sector2 <= sector1;
    val2    <= val1;
    wp2     <= hsvrgb_pkg::WEIGHT_W'(sat1) *
               hsvrgb_pkg::WEIGHT_W'(hsvrgb_pkg::SECTOR_SPAN);
    wq2     <= hsvrgb_pkg::WEIGHT_W'(sat1) * hsvrgb_pkg::WEIGHT_W'(frac1);
    wt2     <= hsvrgb_pkg::WEIGHT_W'(sat1) *
               (hsvrgb_pkg::WEIGHT_W'(hsvrgb_pkg::SECTOR_SPAN) -
                hsvrgb_pkg::WEIGHT_W'(frac1));

    sector_d[0] <= sector2;
    sector_d[1] <= sector_d[0];
    sector_d[2] <= sector_d[1];
    val_d[0]    <= val2;
    val_d[1]    <= val_d[0];
    val_d[2]    <= val_d[1];

    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

endmodule

// ===== hw/rtl/hsvrgb_level.sv =====
// Three-stage unit forming floor(v * (15300 - w) / 15300) for one colour level.
// Depends on hsvrgb_pkg; the division uses a reciprocal estimate and one correction.
`timescale 1ns / 1ps

module hsvrgb_level (
  input  logic                             clk,
  input  logic [hsvrgb_pkg::CHAN_W-1:0]    value,
  input  logic [hsvrgb_pkg::WEIGHT_W-1:0]  weight,
  output logic [hsvrgb_pkg::CHAN_W-1:0]    level
);

  logic [hsvrgb_pkg::PROD_W-1:0] prod_a;
  logic [hsvrgb_pkg::PROD_W-1:0] prod_b;
  logic [hsvrgb_pkg::CHAN_W-1:0] est_b;
  logic [hsvrgb_pkg::EST_W-1:0]  est_full;
  logic [hsvrgb_pkg::PROD_W-1:0] rem_c;

  assign est_full = hsvrgb_pkg::EST_W'(prod_a) * hsvrgb_pkg::EST_W'(hsvrgb_pkg::RECIP);

  assign rem_c = prod_b - (hsvrgb_pkg::PROD_W'(est_b) *
                           hsvrgb_pkg::PROD_W'(hsvrgb_pkg::FULL_SCALE));

  always_ff @(posedge clk) begin
    prod_a <= hsvrgb_pkg::PROD_W'(value) *
              hsvrgb_pkg::PROD_W'(hsvrgb_pkg::FULL_SCALE - weight);
    prod_b <= prod_a;
    est_b  <= est_full[hsvrgb_pkg::RECIP_SHIFT +: hsvrgb_pkg::CHAN_W];
    if (rem_c >= hsvrgb_pkg::PROD_W'(hsvrgb_pkg::FULL_SCALE)) begin
      level <= est_b + 8'd1;
    end else begin
      level <= est_b;
    end
  end

endmodule

// ===== bench/tb_hsv_to_rgb_converter_core.sv =====
// Self-checking bench for hsv_to_rgb_converter_core: a table of directed colours, then random
// requests with random gaps, checked against typed-in colours or a six-sector predictor.
// Depends on hsvrgb_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter_core;
  import hsvrgb_pkg::*;

  localparam int CHAN_MAX       = 255;
  localparam int RANDOM_COUNT   = 450;
  localparam int MAX_GAP        = 14;
  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DIRECTED_COUNT = 25;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] bri;
    logic              typed_in;
    rgb_t              rgb;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [HUE_W-1:0]  hue;
  logic [CHAN_W-1:0] saturation;
  logic [CHAN_W-1:0] brightness;
  logic              done;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  logic req_typed_in;
  rgb_t req_rgb;
  rgb_t colour_queue [$];
  int   fail_count;
  int   idle_cycles;
  int   burst_left;

  hsv_to_rgb_converter_core dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic rgb_t hsv_colour(input logic [HUE_W-1:0] h, input logic [CHAN_W-1:0] s,
                                      input logic [CHAN_W-1:0] v);
    logic [SECTOR_W-1:0] sector;
    int unsigned         frac;
    int unsigned         scale;
    int unsigned         p;
    int unsigned         q;
    int unsigned         t;
    rgb_t                c;
    sector = SECTOR_W'(h / SECTOR_SPAN);
    frac   = h % SECTOR_SPAN;
    scale  = int'(FULL_SCALE);
    p      = (v * (CHAN_MAX - s)) / CHAN_MAX;
    q      = (v * (scale - s * frac)) / scale;
    t      = (v * (scale - s * (SECTOR_SPAN - frac))) / scale;
    if (s == 0) begin
      c = '{v, v, v};
    end else begin
      case (sector)
        SECTOR_RED:    c = '{v, t[7:0], p[7:0]};
        SECTOR_YELLOW: c = '{q[7:0], v, p[7:0]};
        SECTOR_GREEN:  c = '{p[7:0], v, t[7:0]};
        SECTOR_CYAN:   c = '{p[7:0], q[7:0], v};
        SECTOR_BLUE:   c = '{t[7:0], p[7:0], v};
        default:       c = '{v, p[7:0], q[7:0]};
      endcase
    end
    return c;
  endfunction

  function automatic stim_row_t make_row(input int h, input int s, input int b, input bit typed_in,
                                         input int r, input int g, input int bl);
    stim_row_t row;
    row.hue      = HUE_W'(h);
    row.sat      = CHAN_W'(s);
    row.bri      = CHAN_W'(b);
    row.typed_in = typed_in;
    row.rgb      = '{CHAN_W'(r), CHAN_W'(g), CHAN_W'(bl)};
    return row;
  endfunction

  task automatic send_colour(input logic [HUE_W-1:0] h, input logic [CHAN_W-1:0] s,
                             input logic [CHAN_W-1:0] b, input logic typed_in, input rgb_t rgb);
    int gap;
    gap = (burst_left > 0) ? 0 : $urandom_range(0, MAX_GAP);
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 30);
    end
    repeat (gap) begin
      start      <= 1'b0;
      hue        <= HUE_W'($urandom);
      saturation <= CHAN_W'($urandom);
      brightness <= CHAN_W'($urandom);
      @(posedge clk);
    end
    start        <= 1'b1;
    hue          <= h;
    saturation   <= s;
    brightness   <= b;
    req_typed_in <= typed_in;
    req_rgb      <= rgb;
    do @(posedge clk); while (busy);
  endtask

  always @(posedge clk) begin : check_results
    rgb_t want;
    logic accepted;
    accepted = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        colour_queue.push_back(req_typed_in ? req_rgb : hsv_colour(hue, saturation, brightness));
        accepted = 1'b1;
      end
      if (done) begin
        accepted = 1'b1;
        if (colour_queue.size() == 0) begin
          $error("result with no request outstanding: red %0d green %0d blue %0d",
                 red, green, blue);
          fail_count++;
        end else begin
          want = colour_queue.pop_front();
          if (red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, red);
            fail_count++;
          end
          if (green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, green);
            fail_count++;
          end
          if (blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, blue);
            fail_count++;
          end
        end
      end
      idle_cycles = accepted ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t   directed_rows [DIRECTED_COUNT];
    logic [HUE_W-1:0]  h;
    logic [CHAN_W-1:0] s;
    logic [CHAN_W-1:0] b;
    rst          = 1'b1;
    start        = 1'b0;
    hue          = '0;
    saturation   = '0;
    brightness   = '0;
    req_typed_in = 1'b0;
    req_rgb      = '0;
    fail_count   = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    // Grey, primaries and secondaries are typed in; the rest go through the predictor.
    directed_rows = '{
      make_row(  0,   0,   0, 1'b1,   0,   0,   0),
      make_row(  0,   0, 255, 1'b1, 255, 255, 255),
      make_row(359,   0, 128, 1'b1, 128, 128, 128),
      make_row(  0, 255, 255, 1'b1, 255,   0,   0),
      make_row(120, 255, 255, 1'b1,   0, 255,   0),
      make_row(240, 255, 255, 1'b1,   0,   0, 255),
      make_row(200, 255,   0, 1'b1,   0,   0,   0),
      make_row( 60, 255, 255, 1'b1, 255, 255,   0),
      make_row(180, 255, 255, 1'b1,   0, 255, 255),
      make_row(300, 255, 255, 1'b1, 255,   0, 255),
      make_row( 30, 255, 255, 1'b0,   0,   0,   0),
      make_row( 90, 128, 200, 1'b0,   0,   0,   0),
      make_row(150,   1, 255, 1'b0,   0,   0,   0),
      make_row(210, 200, 100, 1'b0,   0,   0,   0),
      make_row(270,  64, 255, 1'b0,   0,   0,   0),
      make_row(330, 255,  17, 1'b0,   0,   0,   0),
      make_row(359, 255, 255, 1'b0,   0,   0,   0),
      make_row( 59, 255, 255, 1'b0,   0,   0,   0),
      make_row(360, 255, 255, 1'b0,   0,   0,   0),
      make_row(420, 170,  85, 1'b0,   0,   0,   0),
      make_row(480, 255, 255, 1'b0,   0,   0,   0),
      make_row(511, 255, 255, 1'b0,   0,   0,   0),
      make_row(256,  85, 170, 1'b0,   0,   0,   0),
      make_row(  1, 254, 254, 1'b0,   0,   0,   0),
      make_row(119, 127,   1, 1'b0,   0,   0,   0)
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_colour(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].bri,
                  directed_rows[i].typed_in, directed_rows[i].rgb);
    end

    // Hues past 359 are rare on purpose; saturation and value lean towards their extremes.
    repeat (RANDOM_COUNT) begin
      h = ($urandom_range(0, 7) == 0) ? HUE_W'($urandom_range(360, 511))
                                      : HUE_W'($urandom_range(0, 359));
      case ($urandom_range(0, 9))
        0:       s = '0;
        1:       s = '1;
        default: s = CHAN_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:       b = '0;
        1:       b = '1;
        default: b = CHAN_W'($urandom);
      endcase
      send_colour(h, s, b, 1'b0, '0);
    end

    start <= 1'b0;
    while (colour_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_level.sv
hw/rtl/hsv_to_rgb_converter_core.sv
bench/tb_hsv_to_rgb_converter_core.sv
